FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; clock i_clk, reset i_rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tsn_pkg.sv
// ----------------------------------------------------------------------------
// tsn_pkg
// Types, status codes and calendar/time constants of the tick time stamp
// normalizer
// ----------------------------------------------------------------------------
package tsn_pkg;

    // payload types
    typedef logic        [63:0] t_chars;
    typedef logic        [3:0]  t_len;
    typedef logic signed [10:0] t_millis;
    typedef logic signed [62:0] t_usec;
    typedef logic        [2:0]  t_status;

    // status codes
    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_TIME  = 3'd1;
    localparam t_status ST_DIGIT = 3'd2;
    localparam t_status ST_DLEN  = 3'd3;
    localparam t_status ST_DATE  = 3'd4;

    // string lengths
    localparam t_len FULL_LEN = 4'd8;
    localparam t_len NO_DAY   = 4'd0;

    // ascii characters
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    // field limits
    localparam int HOUR_MAX = 23;
    localparam int MIN_MAX  = 59;
    localparam int MS_MAX   = 999;

    // time constants in microseconds, epoch offset in days
    localparam longint US_PER_DAY  = 64'sd86400000000;
    localparam longint ZONE_US     = 64'sd28800000000;
    localparam longint HALF_DAY_US = 64'sd43200000000;
    localparam longint EPOCH_DAYS  = 64'sd719468;

    // one day is an odd factor times a power of two
    localparam int     DAY_SHIFT = 13;
    localparam longint DAY_ODD   = US_PER_DAY >> DAY_SHIFT;

    // residues of powers of two modulo the odd day factor
    localparam logic [23:0] RES_24  = 24'((longint'(1) << 24) % DAY_ODD);
    localparam logic [23:0] RES_32  = 24'((longint'(1) << 32) % DAY_ODD);
    localparam logic [23:0] RES_40  = 24'((longint'(1) << 40) % DAY_ODD);
    localparam logic [23:0] RES_48  = 24'((longint'(1) << 48) % DAY_ODD);
    localparam logic [23:0] RES_49  = 24'((longint'(1) << 49) % DAY_ODD);
    localparam logic [23:0] RES_N50 = 24'(DAY_ODD - ((longint'(1) << 50) % DAY_ODD));

    // reciprocal of the odd day factor, scaled by 2^36
    localparam logic [12:0] RECIP = 13'((longint'(1) << 36) / DAY_ODD);

    // output bounds
    localparam t_usec USEC_MAX = {1'b0, {62{1'b1}}};
    localparam t_usec USEC_MIN = {1'b1, {62{1'b0}}};

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHR_ZERO) && (c <= CHR_NINE);
    endfunction

    function automatic logic [3:0] digit_val(input logic [7:0] c);
        return c[3:0];
    endfunction

    // days in a month, february by leap flag
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // day offset of a month's first day in a year that starts in march
    function automatic logic [8:0] month_base(input logic [3:0] m);
        logic [8:0] base;
        case (m)
            4'd1:    base = 9'd306;
            4'd2:    base = 9'd337;
            4'd4:    base = 9'd31;
            4'd5:    base = 9'd61;
            4'd6:    base = 9'd92;
            4'd7:    base = 9'd122;
            4'd8:    base = 9'd153;
            4'd9:    base = 9'd184;
            4'd10:   base = 9'd214;
            4'd11:   base = 9'd245;
            4'd12:   base = 9'd275;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

FILE: rtl/tsn_chan_if.sv
// ----------------------------------------------------------------------------
// tsn_chan_if
// Valid/ready channels of the normalizer: time stamp items in, results out
// ----------------------------------------------------------------------------

// input item channel
interface tsn_in_if;
    import tsn_pkg::*;

    logic    valid;
    logic    ready;
    t_chars  time_chars;
    t_len    time_length;
    t_millis millis;
    t_chars  day_chars;
    t_len    day_length;
    t_usec   receive_us;

    modport source (
        output valid, time_chars, time_length, millis, day_chars, day_length,
               receive_us,
        input  ready
    );
    modport sink (
        input  valid, time_chars, time_length, millis, day_chars, day_length,
               receive_us,
        output ready
    );
endinterface

// result item channel
interface tsn_out_if;
    import tsn_pkg::*;

    logic    valid;
    logic    ready;
    t_usec   event_us;
    t_status status;

    modport source (output valid, event_us, status, input ready);
    modport sink   (input valid, event_us, status, output ready);
endinterface

FILE: rtl/tick_timestamp_normalizer.sv
// ----------------------------------------------------------------------------
// tick_timestamp_normalizer
// Checks an HH:MM:SS time, milliseconds and optional YYYYMMDD day, and turns
// them into UTC microseconds for a UTC+8 local zone
// ----------------------------------------------------------------------------
//  port     dir  items
//  i_in     in   time_chars, time_length, millis, day_chars, day_length,
//                receive_us
//  o_out    out  event_us, status
//
//  one item accepted per cycle while no result is held at the output
//  the modulo-a-day of the receive time sets the depth: a residue fold,
//  a reciprocal quotient estimate and one correcting subtract
//  reset clears the stage valid flags only
//  a result held at the output freezes every stage; i_in.ready follows
//  o_out.ready whenever the output register is full
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tick_timestamp_normalizer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsn_in_if.sink    i_in,
    tsn_out_if.source o_out
);
    import tsn_pkg::*;

    localparam int NSTAGE = 9;

    // pipeline control
    logic [NSTAGE-1:0] r_vld;
    logic              adv;

    // stage 0: captured item
    t_chars  r_s0_tchars, r_s0_dchars;
    t_len    r_s0_tlen, r_s0_dlen;
    t_millis r_s0_ms;
    t_usec   r_s0_recv;

    // stage 1: parsed fields
    t_status            r_s1_status, n_s1_status;
    logic               r_s1_nodate, n_s1_nodate;
    logic [4:0]         r_s1_hh;
    logic [5:0]         r_s1_mi, r_s1_ss;
    logic [9:0]         r_s1_ms;
    logic [13:0]        r_s1_y, n_s1_y;
    logic [6:0]         r_s1_cen, n_s1_cen;
    logic               r_s1_b, n_s1_b;
    logic [8:0]         r_s1_doy, n_s1_doy;
    logic               r_s1_z4, n_s1_z4, r_s1_z100, n_s1_z100, r_s1_z400, n_s1_z400;
    logic signed [63:0] r_s1_x, n_s1_x;
    t_usec              r_s1_recv;
    logic [6:0]         n_s1_hh, n_s1_mi, n_s1_ss;

    // stage 2
    t_status            r_s2_status;
    logic               r_s2_nodate;
    logic [16:0]        r_s2_sec, n_s2_sec;
    logic [9:0]         r_s2_ms;
    logic signed [23:0] r_s2_days, n_s2_days;
    logic [23:0]        r_s2_lo24;
    logic [31:0]        r_s2_p1, r_s2_p2, r_s2_p3, n_s2_p1, n_s2_p2, n_s2_p3;
    logic [25:0]        r_s2_p4, n_s2_p4;
    logic [12:0]        r_s2_xlo;
    t_usec              r_s2_recv;

    // stage 3
    t_status            r_s3_status;
    logic               r_s3_nodate;
    logic [26:0]        r_s3_msec, n_s3_msec;
    logic signed [47:0] r_s3_prod, n_s3_prod;
    logic [32:0]        r_s3_sum, n_s3_sum;
    logic [12:0]        r_s3_xlo;
    t_usec              r_s3_recv;

    // stage 4
    t_status            r_s4_status;
    logic               r_s4_nodate;
    logic [36:0]        r_s4_tod, n_s4_tod;
    logic signed [47:0] r_s4_prod;
    logic [32:0]        r_s4_sum;
    logic [9:0]         r_s4_qe, n_s4_qe;
    logic [25:0]        n_s4_qprod;
    logic [12:0]        r_s4_xlo;
    t_usec              r_s4_recv;

    // stage 5
    t_status            r_s5_status;
    logic               r_s5_nodate;
    logic [36:0]        r_s5_tod;
    logic [24:0]        r_s5_r0, n_s5_r0;
    logic signed [63:0] r_s5_dbase, n_s5_dbase;
    logic [12:0]        r_s5_xlo;
    t_usec              r_s5_recv;

    // stage 6
    t_status            r_s6_status;
    logic               r_s6_nodate;
    logic [36:0]        r_s6_tod;
    logic [23:0]        r_s6_rem, n_s6_rem;
    logic signed [63:0] r_s6_dbase;
    logic [12:0]        r_s6_xlo;
    t_usec              r_s6_recv;

    // stage 7
    t_status            r_s7_status;
    logic               r_s7_nodate;
    logic signed [38:0] r_s7_off, n_s7_off, n_s7_delta;
    logic signed [63:0] r_s7_dbase;
    t_usec              r_s7_recv;

    // stage 8: result register
    t_status            r_s8_status;
    t_usec              r_s8_event, n_s8_event;
    logic signed [63:0] n_s8_sum, n_s8_pick;

    // stage 1 working signals
    logic [7:0] tch [8];
    logic [7:0] dch [8];
    logic       t_fmt_bad, t_dig_ok, t_rng_bad, d_dig_ok, leap, mon_ok, dom_ok;
    logic [6:0] mon, dom;

    // stage 2 working signals
    logic [50:0]        xh;
    logic signed [24:0] yp, f4, f100, f400;

    // whole pipeline moves unless a result is held
    assign adv        = !r_vld[NSTAGE-1] || o_out.ready;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTAGE-2:0], i_in.valid};
        end
    end

    // stage 1: character checks, digit values, status priority
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            tch[i] = r_s0_tchars[63-8*i -: 8];
            dch[i] = r_s0_dchars[63-8*i -: 8];
        end

        t_fmt_bad = (r_s0_tlen != FULL_LEN) || (tch[2] != CHR_COLON)
                 || (tch[5] != CHR_COLON) || (r_s0_ms < 11'sd0)
                 || (r_s0_ms > 11'(MS_MAX));
        t_dig_ok  = is_digit(tch[0]) && is_digit(tch[1]) && is_digit(tch[3])
                 && is_digit(tch[4]) && is_digit(tch[6]) && is_digit(tch[7]);
        n_s1_hh   = 7'(digit_val(tch[0])) * 7'd10 + 7'(digit_val(tch[1]));
        n_s1_mi   = 7'(digit_val(tch[3])) * 7'd10 + 7'(digit_val(tch[4]));
        n_s1_ss   = 7'(digit_val(tch[6])) * 7'd10 + 7'(digit_val(tch[7]));
        t_rng_bad = (n_s1_hh > 7'(HOUR_MAX)) || (n_s1_mi > 7'(MIN_MAX))
                 || (n_s1_ss > 7'(MIN_MAX));

        d_dig_ok = 1'b1;
        for (int i = 0; i < 8; i++) begin
            d_dig_ok = d_dig_ok && is_digit(dch[i]);
        end
        n_s1_cen  = 7'(digit_val(dch[0])) * 7'd10 + 7'(digit_val(dch[1]));
        n_s1_y    = 14'(n_s1_cen) * 14'd100 + 14'(digit_val(dch[2])) * 14'd10
                  + 14'(digit_val(dch[3]));
        mon       = 7'(digit_val(dch[4])) * 7'd10 + 7'(digit_val(dch[5]));
        dom       = 7'(digit_val(dch[6])) * 7'd10 + 7'(digit_val(dch[7]));
        n_s1_z4   = (n_s1_y[1:0] == 2'd0);
        n_s1_z100 = (digit_val(dch[2]) == 4'd0) && (digit_val(dch[3]) == 4'd0);
        n_s1_z400 = n_s1_z100 && (n_s1_cen[1:0] == 2'd0);
        leap      = n_s1_z4 && (!n_s1_z100 || n_s1_z400);
        mon_ok    = (mon >= 7'd1) && (mon <= 7'd12);
        dom_ok    = (dom >= 7'd1) && (dom <= 7'(month_len(mon[3:0], leap)));
        n_s1_b    = (mon <= 7'd2);
        n_s1_doy  = month_base(mon[3:0]) + 9'(dom) - 9'd1;

        n_s1_nodate = (r_s0_dlen == NO_DAY);
        if (t_fmt_bad) begin
            n_s1_status = ST_TIME;
        end else if (!t_dig_ok) begin
            n_s1_status = ST_DIGIT;
        end else if (t_rng_bad) begin
            n_s1_status = ST_TIME;
        end else if (n_s1_nodate) begin
            n_s1_status = ST_OK;
        end else if (r_s0_dlen != FULL_LEN) begin
            n_s1_status = ST_DLEN;
        end else if (!d_dig_ok) begin
            n_s1_status = ST_DIGIT;
        end else if (!mon_ok || !dom_ok) begin
            n_s1_status = ST_DATE;
        end else begin
            n_s1_status = ST_OK;
        end

        // local receive time
        n_s1_x = 64'(r_s0_recv) + 64'(ZONE_US);
    end

    // stage 2: seconds of day, day count, residue partial products
    always_comb begin
        n_s2_sec = 17'(r_s1_hh) * 17'd3600 + 17'(r_s1_mi) * 17'd60 + 17'(r_s1_ss);

        // year shifted to start in march, floor terms by borrow
        yp   = 25'(r_s1_y) - 25'(r_s1_b);
        f4   = 25'(r_s1_y[13:2]) - 25'(r_s1_b & r_s1_z4);
        f100 = 25'(r_s1_cen) - 25'(r_s1_b & r_s1_z100);
        f400 = 25'(r_s1_cen[6:2]) - 25'(r_s1_b & r_s1_z400);
        n_s2_days = 24'(yp * 25'd365 + f4 - f100 + f400 + 25'(r_s1_doy)
                        - 25'(EPOCH_DAYS));

        // floor quotient by 2^13 split into weighted chunks
        xh      = r_s1_x[63:DAY_SHIFT];
        n_s2_p1 = 32'(xh[31:24]) * 32'(RES_24);
        n_s2_p2 = 32'(xh[39:32]) * 32'(RES_32);
        n_s2_p3 = 32'(xh[47:40]) * 32'(RES_40);
        n_s2_p4 = (xh[48] ? 26'(RES_48) : 26'd0) + (xh[49] ? 26'(RES_49) : 26'd0)
                + (xh[50] ? 26'(RES_N50) : 26'd0);
    end

    // stage 3: milliseconds of day, day product, residue sum
    always_comb begin
        n_s3_msec = 27'(r_s2_sec) * 27'd1000 + 27'(r_s2_ms);
        n_s3_prod = 48'(r_s2_days) * 48'(DAY_ODD);
        n_s3_sum  = 33'(r_s2_lo24) + 33'(r_s2_p1) + 33'(r_s2_p2) + 33'(r_s2_p3)
                  + 33'(r_s2_p4);
    end

    // stage 4: time of day, quotient estimate (low by at most one)
    always_comb begin
        n_s4_tod   = 37'(r_s3_msec) * 37'd1000;
        n_s4_qprod = 26'(r_s3_sum[32:20]) * 26'(RECIP);
        n_s4_qe    = n_s4_qprod[25:16];
    end

    // stage 5: partial remainder, dated event time
    always_comb begin
        n_s5_r0    = 25'(34'(r_s4_sum) - 34'(r_s4_qe) * 34'(DAY_ODD));
        n_s5_dbase = 64'($signed({r_s4_prod, {DAY_SHIFT{1'b0}}})) + 64'(r_s4_tod)
                   - 64'(ZONE_US);
    end

    // stage 6: final remainder correction
    always_comb begin
        if (r_s5_r0 >= 25'(DAY_ODD)) begin
            n_s6_rem = 24'(r_s5_r0 - 25'(DAY_ODD));
        end else begin
            n_s6_rem = 24'(r_s5_r0);
        end
    end

    // stage 7: offset from receive time, wrapped to the nearest day
    always_comb begin
        n_s7_delta = $signed(39'(r_s6_tod)) - $signed(39'({r_s6_rem, r_s6_xlo}));
        if (n_s7_delta > 39'(HALF_DAY_US)) begin
            n_s7_off = n_s7_delta - 39'(US_PER_DAY);
        end else if (n_s7_delta < 39'(-HALF_DAY_US)) begin
            n_s7_off = n_s7_delta + 39'(US_PER_DAY);
        end else begin
            n_s7_off = n_s7_delta;
        end
    end

    // stage 8: select, saturate, zero on error
    always_comb begin
        n_s8_sum  = 64'(r_s7_recv) + 64'(r_s7_off);
        n_s8_pick = r_s7_nodate ? n_s8_sum : r_s7_dbase;
        if (r_s7_status != ST_OK) begin
            n_s8_event = '0;
        end else if (n_s8_pick > 64'(USEC_MAX)) begin
            n_s8_event = USEC_MAX;
        end else if (n_s8_pick < 64'(USEC_MIN)) begin
            n_s8_event = USEC_MIN;
        end else begin
            n_s8_event = 63'(n_s8_pick);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_tchars <= i_in.time_chars;
            r_s0_tlen   <= i_in.time_length;
            r_s0_ms     <= i_in.millis;
            r_s0_dchars <= i_in.day_chars;
            r_s0_dlen   <= i_in.day_length;
            r_s0_recv   <= i_in.receive_us;

            r_s1_status <= n_s1_status;
            r_s1_nodate <= n_s1_nodate;
            r_s1_hh     <= n_s1_hh[4:0];
            r_s1_mi     <= n_s1_mi[5:0];
            r_s1_ss     <= n_s1_ss[5:0];
            r_s1_ms     <= r_s0_ms[9:0];
            r_s1_y      <= n_s1_y;
            r_s1_cen    <= n_s1_cen;
            r_s1_b      <= n_s1_b;
            r_s1_doy    <= n_s1_doy;
            r_s1_z4     <= n_s1_z4;
            r_s1_z100   <= n_s1_z100;
            r_s1_z400   <= n_s1_z400;
            r_s1_x      <= n_s1_x;
            r_s1_recv   <= r_s0_recv;

            r_s2_status <= r_s1_status;
            r_s2_nodate <= r_s1_nodate;
            r_s2_sec    <= n_s2_sec;
            r_s2_ms     <= r_s1_ms;
            r_s2_days   <= n_s2_days;
            r_s2_lo24   <= r_s1_x[DAY_SHIFT+23:DAY_SHIFT];
            r_s2_p1     <= n_s2_p1;
            r_s2_p2     <= n_s2_p2;
            r_s2_p3     <= n_s2_p3;
            r_s2_p4     <= n_s2_p4;
            r_s2_xlo    <= r_s1_x[DAY_SHIFT-1:0];
            r_s2_recv   <= r_s1_recv;

            r_s3_status <= r_s2_status;
            r_s3_nodate <= r_s2_nodate;
            r_s3_msec   <= n_s3_msec;
            r_s3_prod   <= n_s3_prod;
            r_s3_sum    <= n_s3_sum;
            r_s3_xlo    <= r_s2_xlo;
            r_s3_recv   <= r_s2_recv;

            r_s4_status <= r_s3_status;
            r_s4_nodate <= r_s3_nodate;
            r_s4_tod    <= n_s4_tod;
            r_s4_prod   <= r_s3_prod;
            r_s4_sum    <= r_s3_sum;
            r_s4_qe     <= n_s4_qe;
            r_s4_xlo    <= r_s3_xlo;
            r_s4_recv   <= r_s3_recv;

            r_s5_status <= r_s4_status;
            r_s5_nodate <= r_s4_nodate;
            r_s5_tod    <= r_s4_tod;
            r_s5_r0     <= n_s5_r0;
            r_s5_dbase  <= n_s5_dbase;
            r_s5_xlo    <= r_s4_xlo;
            r_s5_recv   <= r_s4_recv;

            r_s6_status <= r_s5_status;
            r_s6_nodate <= r_s5_nodate;
            r_s6_tod    <= r_s5_tod;
            r_s6_rem    <= n_s6_rem;
            r_s6_dbase  <= r_s5_dbase;
            r_s6_xlo    <= r_s5_xlo;
            r_s6_recv   <= r_s5_recv;

            r_s7_status <= r_s6_status;
            r_s7_nodate <= r_s6_nodate;
            r_s7_off    <= n_s7_off;
            r_s7_dbase  <= r_s6_dbase;
            r_s7_recv   <= r_s6_recv;

            r_s8_status <= r_s7_status;
            r_s8_event  <= n_s8_event;
        end
    end

    // result channel
    assign o_out.valid    = r_vld[NSTAGE-1];
    assign o_out.event_us = r_s8_event;
    assign o_out.status   = r_s8_status;

    // checks
    `ASSERT_IMPLY(a_err_zero, o_out.valid && (o_out.status != ST_OK), o_out.event_us == '0, "error result carries a nonzero time")
    `ASSERT_IMPLY(a_stall_in, o_out.valid && !o_out.ready, !i_in.ready, "item taken while the result is held")
    `ASSERT_IMPLY(a_rem_range, r_vld[6], r_s6_rem < 24'(DAY_ODD), "day residue not fully reduced")
    `ASSERT_NEXT(a_adv_move, adv && i_in.valid, r_vld[0], "accepted item lost at the first stage")

endmodule

FILE: sim/tick_timestamp_normalizer_test.sv
// ----------------------------------------------------------------------------
// tick_timestamp_normalizer_test
// Self-checking bench for the tick time stamp normalizer. Directed items
// cover the calendar, every field check and the day rollover around the
// receive time. Random items follow, mostly well-formed time stamps with
// some corrupted ones. A local predictor computes each expected result.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tick_timestamp_normalizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tsn_pkg::*;

    // time constants in microseconds
    localparam longint HOUR_US   = 64'sd3_600_000_000;
    localparam longint DAY_US    = 24 * HOUR_US;
    localparam longint TZ_US     = 8 * HOUR_US;
    localparam longint HALF_US   = 12 * HOUR_US;
    localparam longint EV_MAX    = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam longint EV_MIN    = -EV_MAX - 1;
    // days from 0000-01-01 to 1970-01-01
    localparam longint EPOCH_DAY = 64'sd719_528;
    // 2000-01-01 and a span of about 41 years for realistic receive times
    localparam longint REAL_BASE = 64'sd946_684_800_000_000;
    localparam longint REAL_SPAN = 64'sd1_300_000_000_000_000;
    localparam longint NOW_US    = 64'sd1_700_000_000_000_000;
    localparam int     PIPE_DEPTH = 9;

    typedef struct {
        t_chars  time_chars;
        t_len    time_length;
        t_millis millis;
        t_chars  day_chars;
        t_len    day_length;
        t_usec   receive_us;
    } tick_t;

    typedef struct {
        t_usec   event_us;
        t_status status;
    } utc_stamp_t;

    logic i_clk;
    logic i_rst_n;

    tsn_in_if  tick_in ();
    tsn_out_if stamp_out ();

    tick_timestamp_normalizer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_in.sink),
        .o_out   (stamp_out.source)
    );

    utc_stamp_t pending_stamps[$];
    int         mismatches = 0;
    bit         sender_gaps = 1'b1;

    // ------------------------------------------------------------------------
    // text and calendar helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] char_of(t_chars w, int pos);
        return w[63 - 8 * pos -: 8];
    endfunction

    function automatic t_chars poke_char(t_chars w, int pos, logic [7:0] c);
        w[63 - 8 * pos -: 8] = c;
        return w;
    endfunction

    function automatic logic [7:0] digit_chr(int v);
        return CHR_ZERO + 8'(v % 10);
    endfunction

    function automatic t_chars clock_text(int hh, int mm, int ss);
        return {digit_chr(hh / 10), digit_chr(hh), CHR_COLON,
                digit_chr(mm / 10), digit_chr(mm), CHR_COLON,
                digit_chr(ss / 10), digit_chr(ss)};
    endfunction

    function automatic t_chars date_text(int y, int m, int d);
        return {digit_chr(y / 1000), digit_chr(y / 100), digit_chr(y / 10), digit_chr(y),
                digit_chr(m / 10), digit_chr(m), digit_chr(d / 10), digit_chr(d)};
    endfunction

    function automatic logic [7:0] stray_char();
        case ($urandom_range(0, 3))
            0:       return "/";
            1:       return ":";
            2:       return "-";
            default: return "+";
        endcase
    endfunction

    // decimal value of cnt characters from pos; returns 0 on any non-digit
    function automatic bit read_number(t_chars w, int pos, int cnt, output longint num);
        logic [7:0] c;
        num = 0;
        for (int i = 0; i < cnt; i++) begin
            c = char_of(w, pos + i);
            if (c < CHR_ZERO || c > CHR_NINE)
                return 1'b0;
            num = num * 10 + longint'(c - CHR_ZERO);
        end
        return 1'b1;
    endfunction

    function automatic bit leap_year(longint y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic longint month_days(longint y, longint m);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // counts whole years since year 0, then months, then days
    function automatic longint days_from_epoch(longint y, longint m, longint d);
        longint n;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (longint k = 1; k < m; k++)
            n += month_days(y, k);
        return n + d - 1 - EPOCH_DAY;
    endfunction

    function automatic longint floor_mod(longint a, longint b);
        longint r;
        r = a % b;
        if (r < 0)
            r += b;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // predictor: event time and status of one item
    // ------------------------------------------------------------------------
    function automatic utc_stamp_t utc_stamp_of(tick_t t);
        utc_stamp_t res;
        longint     recv, ms, hh, mi, ss, tod, yr, mo, dy, loc_recv, loc_ev, ev;
        res.status = ST_OK;
        ev = 0;
        recv = t.receive_us;
        ms = t.millis;
        if (t.time_length != FULL_LEN || char_of(t.time_chars, 2) != CHR_COLON
            || char_of(t.time_chars, 5) != CHR_COLON || ms < 0 || ms > 999) begin
            res.status = ST_TIME;
        end else if (!read_number(t.time_chars, 0, 2, hh)
                     || !read_number(t.time_chars, 3, 2, mi)
                     || !read_number(t.time_chars, 6, 2, ss)) begin
            res.status = ST_DIGIT;
        end else if (hh > 23 || mi > 59 || ss > 59) begin
            res.status = ST_TIME;
        end else begin
            tod = ((hh * 3600 + mi * 60 + ss) * 1000 + ms) * 1000;
            if (t.day_length == NO_DAY) begin
                // local day of the receive time, moved by a day past half a day
                loc_recv = recv + TZ_US;
                loc_ev = loc_recv - floor_mod(loc_recv, DAY_US) + tod;
                if (loc_ev - loc_recv > HALF_US)
                    loc_ev -= DAY_US;
                else if (loc_ev - loc_recv < -HALF_US)
                    loc_ev += DAY_US;
                ev = loc_ev - TZ_US;
            end else if (t.day_length != FULL_LEN) begin
                res.status = ST_DLEN;
            end else if (!read_number(t.day_chars, 0, 4, yr)
                         || !read_number(t.day_chars, 4, 2, mo)
                         || !read_number(t.day_chars, 6, 2, dy)) begin
                res.status = ST_DIGIT;
            end else if (mo < 1 || mo > 12 || dy < 1 || dy > month_days(yr, mo)) begin
                res.status = ST_DATE;
            end else begin
                ev = days_from_epoch(yr, mo, dy) * DAY_US + tod - TZ_US;
            end
        end
        // saturate to the 63-bit range
        if (ev > EV_MAX)
            ev = EV_MAX;
        else if (ev < EV_MIN)
            ev = EV_MIN;
        res.event_us = t_usec'(ev);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // item construction
    // ------------------------------------------------------------------------
    function automatic tick_t make_tick(t_chars tc, t_len tl, int ms, t_chars dc, t_len dl,
                                        longint rcv);
        tick_t t;
        t.time_chars  = tc;
        t.time_length = tl;
        t.millis      = t_millis'(ms);
        t.day_chars   = dc;
        t.day_length  = dl;
        t.receive_us  = t_usec'(rcv);
        return t;
    endfunction

    // time text and millis for a time of day in microseconds
    function automatic tick_t with_event_tod(tick_t t, longint tod_us);
        longint tod_ms;
        tod_ms = tod_us / 1000;
        t.time_chars = clock_text(int'(tod_ms / 3_600_000), int'(tod_ms / 60_000 % 60),
                                  int'(tod_ms / 1000 % 60));
        t.millis = t_millis'(tod_ms % 1000);
        return t;
    endfunction

    function automatic tick_t random_tick();
        tick_t     t;
        bit [63:0] r;
        longint    recv, rtod, tod;
        int        roll, pos, yr, mo, dy, v;
        // receive time: mostly realistic, some full range, some near the bounds
        r = {$urandom(), $urandom()};
        roll = $urandom_range(0, 99);
        if (roll < 70)
            recv = REAL_BASE + longint'(r % REAL_SPAN);
        else if (roll < 85)
            recv = $signed(r[62:0]);
        else if (roll < 93)
            recv = EV_MAX - longint'(r % (2 * DAY_US));
        else
            recv = EV_MIN + longint'(r % (2 * DAY_US));

        // event time of day: near the receive time, half a day off to within a millisecond, or anywhere
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            recv -= floor_mod(recv, 1000);
            if (recv < EV_MIN)
                recv += 1000;
            rtod = floor_mod(recv + TZ_US, DAY_US);
            pos = $urandom_range(0, 2);
            tod = floor_mod(rtod + ($urandom_range(0, 1) ? HALF_US : -HALF_US)
                            + longint'(pos - 1) * 1000, DAY_US);
        end else if (roll < 60) begin
            rtod = floor_mod(recv + TZ_US, DAY_US);
            r = {$urandom(), $urandom()};
            tod = floor_mod(rtod + longint'(r % (28 * HOUR_US)) - 14 * HOUR_US, DAY_US);
        end else begin
            tod = longint'($urandom_range(0, 86_399_999)) * 1000;
        end
        t = make_tick('0, FULL_LEN, 0, '0, NO_DAY, recv);
        t = with_event_tod(t, tod);

        // corrupted time part
        if ($urandom_range(0, 99) < 20) begin
            case ($urandom_range(0, 7))
                0: t.time_length = t_len'($urandom());
                1: t.time_chars = poke_char(t.time_chars, $urandom_range(0, 7),
                                            8'($urandom()));
                2: t.time_chars = {$urandom(), $urandom()};
                3: t.millis = t_millis'($urandom());
                4: begin
                    pos = $urandom_range(0, 5);
                    t.time_chars = poke_char(t.time_chars, pos + pos / 2, stray_char());
                end
                5: begin
                    v = $urandom_range(24, 99);
                    t.time_chars = {digit_chr(v / 10), digit_chr(v), t.time_chars[47:0]};
                end
                6: begin
                    v = $urandom_range(60, 99);
                    pos = $urandom_range(0, 1) ? 3 : 6;
                    t.time_chars = poke_char(poke_char(t.time_chars, pos, digit_chr(v / 10)),
                                             pos + 1, digit_chr(v));
                end
                default: begin
                    v = $urandom_range(1, 1024);
                    t.millis = $urandom_range(0, 1) ? t_millis'(999 + v % 25) : t_millis'(-v);
                end
            endcase
        end

        // trade day: absent, a valid or corrupted date, or a bad length
        yr = ($urandom_range(0, 3) != 0) ? $urandom_range(1970, 2100) : $urandom_range(0, 9999);
        mo = $urandom_range(1, 12);
        dy = $urandom_range(1, month_days(yr, mo));
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            t.day_length = NO_DAY;
            t.day_chars = $urandom_range(0, 1) ? {$urandom(), $urandom()} : date_text(yr, mo, dy);
        end else if (roll < 90) begin
            t.day_length = FULL_LEN;
            t.day_chars = date_text(yr, mo, dy);
            if ($urandom_range(0, 99) < 20) begin
                case ($urandom_range(0, 5))
                    0: t.day_chars = date_text(yr, $urandom_range(0, 99), dy);
                    1: t.day_chars = date_text(yr, mo, $urandom_range(0, 99));
                    2: t.day_chars = date_text(yr, 2, 29);
                    3: t.day_chars = poke_char(t.day_chars, $urandom_range(0, 7),
                                               8'($urandom()));
                    4: t.day_chars = {$urandom(), $urandom()};
                    default: t.day_chars = poke_char(t.day_chars, $urandom_range(0, 7),
                                                     stray_char());
                endcase
            end
        end else begin
            t.day_length = t_len'($urandom());
            t.day_chars = date_text(yr, mo, dy);
        end
        return t;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // item sender and result drain
    // ------------------------------------------------------------------------
    task automatic send_tick(tick_t t);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            tick_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_in.valid       <= 1'b1;
        tick_in.time_chars  <= t.time_chars;
        tick_in.time_length <= t.time_length;
        tick_in.millis      <= t.millis;
        tick_in.day_chars   <= t.day_chars;
        tick_in.day_length  <= t.day_length;
        tick_in.receive_us  <= t.receive_us;
        do @(posedge i_clk); while (tick_in.ready !== 1'b1);
    endtask

    // hold off the sender until every pending result is out
    task automatic wait_for_results();
        tick_in.valid <= 1'b0;
        while (pending_stamps.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // result sink with random stalls and long ready stretches
    // ------------------------------------------------------------------------
    initial begin
        int burst, stall;
        stamp_out.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            burst = ($urandom_range(0, 99) < 5) ? $urandom_range(100, 300) : $urandom_range(1, 8);
            stamp_out.ready <= 1'b1;
            repeat (burst) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                stamp_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result check, then prediction of newly accepted items
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        tick_t      seen;
        utc_stamp_t want;
        if (i_rst_n) begin
            if (stamp_out.valid && stamp_out.ready) begin
                if (pending_stamps.size() == 0) begin
                    $error("result with no item pending: event_us %0d status %0d",
                           stamp_out.event_us, stamp_out.status);
                    mismatches++;
                end else begin
                    want = pending_stamps.pop_front();
                    if (stamp_out.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status,
                               stamp_out.status);
                        mismatches++;
                    end
                    if (stamp_out.event_us !== want.event_us) begin
                        $error("event_us: expected %0d, actual %0d", want.event_us,
                               stamp_out.event_us);
                        mismatches++;
                    end
                end
            end
            if (tick_in.valid && tick_in.ready) begin
                seen.time_chars  = tick_in.time_chars;
                seen.time_length = tick_in.time_length;
                seen.millis      = tick_in.millis;
                seen.day_chars   = tick_in.day_chars;
                seen.day_length  = tick_in.day_length;
                seen.receive_us  = tick_in.receive_us;
                pending_stamps.push_back(utc_stamp_of(seen));
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // dated items: calendar extremes, leap rules and invalid dates
    task automatic test_calendar_days();
        send_tick(make_tick(clock_text(0, 0, 0), FULL_LEN, 0, date_text(1970, 1, 1),
                            FULL_LEN, NOW_US));
        send_tick(make_tick(clock_text(23, 59, 59), FULL_LEN, 999, date_text(9999, 12, 31),
                            FULL_LEN, NOW_US));
        // year zero is a leap year
        send_tick(make_tick(clock_text(12, 30, 45), FULL_LEN, 500, date_text(0, 2, 29),
                            FULL_LEN, NOW_US));
        send_tick(make_tick(clock_text(9, 0, 0), FULL_LEN, 0, date_text(1900, 2, 29),
                            FULL_LEN, NOW_US));
        send_tick(make_tick(clock_text(9, 0, 0), FULL_LEN, 0, date_text(2000, 2, 29),
                            FULL_LEN, NOW_US));
        send_tick(make_tick(clock_text(9, 0, 0), FULL_LEN, 0, date_text(2024, 13, 1),
                            FULL_LEN, NOW_US));
        send_tick(make_tick(clock_text(9, 0, 0), FULL_LEN, 0, date_text(2024, 0, 1),
                            FULL_LEN, NOW_US));
        send_tick(make_tick(clock_text(9, 0, 0), FULL_LEN, 0, date_text(2024, 1, 0),
                            FULL_LEN, NOW_US));
        send_tick(make_tick(clock_text(9, 0, 0), FULL_LEN, 0, date_text(2024, 4, 31),
                            FULL_LEN, NOW_US));
        wait_for_results();
    endtask

    // format, digit and range checks of each field, in order of priority
    task automatic test_field_checks();
        t_chars day;
        day = date_text(2024, 5, 17);
        // bad length wins over a minus sign in the hour
        send_tick(make_tick(poke_char(clock_text(12, 0, 0), 0, "-"), 4'd15, 0, day,
                            FULL_LEN, NOW_US));
        send_tick(make_tick(poke_char(clock_text(9, 30, 0), 2, "."), FULL_LEN, 0, day,
                            FULL_LEN, NOW_US));
        send_tick(make_tick(clock_text(9, 30, 0), FULL_LEN, -1024, day, FULL_LEN, NOW_US));
        send_tick(make_tick(clock_text(9, 30, 0), FULL_LEN, 1023, day, FULL_LEN, NOW_US));
        send_tick(make_tick(clock_text(9, 30, 0), FULL_LEN, 1000, day, FULL_LEN, NOW_US));
        send_tick(make_tick(poke_char(clock_text(12, 0, 0), 0, "-"), FULL_LEN, 0, day,
                            FULL_LEN, NOW_US));
        send_tick(make_tick(poke_char(clock_text(12, 0, 0), 4, CHR_COLON), FULL_LEN, 0, day,
                            FULL_LEN, NOW_US));
        send_tick(make_tick(clock_text(24, 0, 0), FULL_LEN, 0, day, FULL_LEN, NOW_US));
        send_tick(make_tick(clock_text(12, 60, 0), FULL_LEN, 0, day, FULL_LEN, NOW_US));
        send_tick(make_tick(clock_text(12, 0, 60), FULL_LEN, 0, day, FULL_LEN, NOW_US));
        send_tick(make_tick(clock_text(12, 0, 0), FULL_LEN, 0, day, 4'd3, NOW_US));
        send_tick(make_tick(clock_text(12, 0, 0), FULL_LEN, 0, poke_char(day, 0, "-"),
                            FULL_LEN, NOW_US));
        wait_for_results();
    endtask

    // no trade day: half-day boundaries and saturation at the range ends
    task automatic test_day_rollover();
        tick_t t;
        // exactly half a day later stays on the same day; the day text is ignored
        send_tick(make_tick(clock_text(20, 0, 0), FULL_LEN, 0, '1, NO_DAY, 0));
        send_tick(make_tick(clock_text(20, 0, 0), FULL_LEN, 1, '0, NO_DAY, 0));
        send_tick(make_tick(clock_text(8, 0, 0), FULL_LEN, 0, '0, NO_DAY, HALF_US));
        send_tick(make_tick(clock_text(7, 59, 59), FULL_LEN, 999, '0, NO_DAY, HALF_US));
        // an hour past the largest receive time, an hour before the smallest
        t = make_tick('0, FULL_LEN, 0, '0, NO_DAY, EV_MAX);
        send_tick(with_event_tod(t, floor_mod(EV_MAX + TZ_US + HOUR_US, DAY_US)));
        t = make_tick('0, FULL_LEN, 0, '0, NO_DAY, EV_MIN);
        send_tick(with_event_tod(t, floor_mod(EV_MIN + TZ_US - HOUR_US, DAY_US)));
        wait_for_results();
    endtask

    // random items, with gap-free stretches and periodic full drains
    task automatic test_random_ticks(int count);
        for (int i = 0; i < count; i++) begin
            sender_gaps = ((i / 150) % 3) != 2;
            if (i > 0 && i % 400 == 0)
                wait_for_results();
            send_tick(random_tick());
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n             <= 1'b0;
        tick_in.valid       <= 1'b0;
        tick_in.time_chars  <= '0;
        tick_in.time_length <= '0;
        tick_in.millis      <= '0;
        tick_in.day_chars   <= '0;
        tick_in.day_length  <= '0;
        tick_in.receive_us  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_calendar_days();
        test_field_checks();
        test_day_rollover();
        test_random_ticks(1125);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
